// File: sv/mdpq_pkg.sv
// ----------------------------------------------------------------------------
// mdpq_pkg
// shared types and constants of the mask disc proximity query core
// ----------------------------------------------------------------------------
package mdpq_pkg;

    localparam int MAX_WIDTH_DEF        = 64;
    localparam int MAX_HEIGHT_DEF       = 64;
    localparam int RADIUS_FRAC_BITS_DEF = 4;

    localparam int POS_W    = 6;
    localparam int PIX_W    = 8;
    localparam int RADIUS_W = 10;
    localparam int GRID_W   = 7;
    localparam int COORD_W  = 7;
    localparam int SPAN_W   = RADIUS_W + 2;
    localparam int SQ_W     = 16;
    localparam int R2_W     = 2 * RADIUS_W;

    localparam int QUEUE_DEPTH = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [POS_W-1:0]     pos_x;
        logic [POS_W-1:0]     pos_y;
        logic                 wr_en;
        logic                 wr_bit;
        logic [RADIUS_W-1:0]  radius;
        logic [COORD_W-1:0]   xs;
        logic [COORD_W-1:0]   xe;
        logic [COORD_W-1:0]   ys;
        logic [COORD_W-1:0]   ye;
        logic                 empty;
    } entry_t;

endpackage

// File: sv/mdpq_front.sv
// ----------------------------------------------------------------------------
// mdpq_front
// classifies requests: write target check and clipped query window
// ----------------------------------------------------------------------------
module mdpq_front #(
    parameter int MAX_WIDTH        = mdpq_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT       = mdpq_pkg::MAX_HEIGHT_DEF,
    parameter int RADIUS_FRAC_BITS = mdpq_pkg::RADIUS_FRAC_BITS_DEF
) (
    input  logic                           s_command,
    input  logic [mdpq_pkg::POS_W-1:0]     s_pos_x,
    input  logic [mdpq_pkg::POS_W-1:0]     s_pos_y,
    input  logic [mdpq_pkg::PIX_W-1:0]     s_pixel_value,
    input  logic [mdpq_pkg::RADIUS_W-1:0]  s_radius_q4,
    input  logic [mdpq_pkg::GRID_W-1:0]    grid_width,
    input  logic [mdpq_pkg::GRID_W-1:0]    grid_height,
    output mdpq_pkg::entry_t               entry
);

    localparam int SW = mdpq_pkg::SPAN_W;
    localparam int CW = mdpq_pkg::COORD_W;
    localparam logic [SW-1:0] ROUND = SW'((1 << RADIUS_FRAC_BITS) - 1);

    logic [CW-1:0]        used_w;
    logic [CW-1:0]        used_h;
    logic [SW-1:0]        half;
    logic signed [SW-1:0] cx_s;
    logic signed [SW-1:0] cy_s;
    logic signed [SW-1:0] xlo_s;
    logic signed [SW-1:0] xhi_s;
    logic signed [SW-1:0] ylo_s;
    logic signed [SW-1:0] yhi_s;
    logic [CW-1:0]        xs;
    logic [CW-1:0]        xe;
    logic [CW-1:0]        ys;
    logic [CW-1:0]        ye;

    always_comb begin
        used_w = (int'(grid_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(grid_width);
        used_h = (int'(grid_height) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(grid_height);

        half = (SW'(s_radius_q4) + ROUND) >> RADIUS_FRAC_BITS;
        cx_s = $signed(SW'(s_pos_x));
        cy_s = $signed(SW'(s_pos_y));

        xlo_s = cx_s - $signed(half);
        xhi_s = cx_s + $signed(half);
        ylo_s = cy_s - $signed(half);
        yhi_s = cy_s + $signed(half);

        xs = xlo_s[SW-1] ? '0 : CW'(xlo_s);
        ys = ylo_s[SW-1] ? '0 : CW'(ylo_s);
        xe = (xhi_s > $signed(SW'(used_w))) ? used_w : CW'(xhi_s);
        ye = (yhi_s > $signed(SW'(used_h))) ? used_h : CW'(yhi_s);

        entry.cmd    = mdpq_pkg::cmd_t'(s_command);
        entry.pos_x  = s_pos_x;
        entry.pos_y  = s_pos_y;
        entry.wr_en  = (CW'(s_pos_x) < used_w) && (CW'(s_pos_y) < used_h);
        entry.wr_bit = |s_pixel_value;
        entry.radius = s_radius_q4;
        entry.xs     = xs;
        entry.xe     = xe;
        entry.ys     = ys;
        entry.ye     = ye;
        entry.empty  = (xs >= xe) || (ys >= ye);
    end

endmodule

// File: sv/mdpq_queue.sv
// ----------------------------------------------------------------------------
// mdpq_queue
// small fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module mdpq_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mdpq_pkg::entry_t  push_data,
    output logic              full,
    input  logic              pop,
    output mdpq_pkg::entry_t  pop_data,
    output logic              empty
);

    localparam int DEPTH = mdpq_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    mdpq_pkg::entry_t slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == NW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

// File: sv/mdpq_back.sv
// ----------------------------------------------------------------------------
// mdpq_back
// mask memory, pixel writes and window scan for proximity queries
// ----------------------------------------------------------------------------
module mdpq_back #(
    parameter int MAX_WIDTH        = mdpq_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT       = mdpq_pkg::MAX_HEIGHT_DEF,
    parameter int RADIUS_FRAC_BITS = mdpq_pkg::RADIUS_FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mdpq_pkg::entry_t  entry,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_in_proximity
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = mdpq_pkg::COORD_W;
    localparam int PW    = mdpq_pkg::POS_W;
    localparam int QW    = mdpq_pkg::SQ_W;
    localparam int R2W   = mdpq_pkg::R2_W;
    localparam int LW    = QW + 2 * RADIUS_FRAC_BITS;
    localparam int CMPW  = (LW > R2W) ? LW : R2W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } state_t;

    logic mask_mem [DEPTH];

    state_t         state_reg;
    logic [CW-1:0]  x_reg;
    logic [CW-1:0]  y_reg;
    logic [CW-1:0]  xs_reg;
    logic [CW-1:0]  xe_reg;
    logic [CW-1:0]  ye_reg;
    logic [PW-1:0]  cx_reg;
    logic [PW-1:0]  cy_reg;
    logic [R2W-1:0] r2_reg;
    logic [QW-1:0]  sq_reg;
    logic           pv_reg;
    logic           acc_reg;
    logic           rd_bit_reg;
    logic           m_valid_reg;
    logic           m_in_proximity_reg;

    logic                 wr_fire;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic                 rd_fire;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic signed [QW-1:0] dxe;
    logic signed [QW-1:0] dye;
    logic [QW-1:0]        sq_next;
    logic [CW-1:0]        x_inc;
    logic [CW-1:0]        y_inc;
    logic                 row_end;
    logic                 last_pix;
    logic                 hit;

    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;
    assign wr_fire = q_pop && (entry.cmd == mdpq_pkg::CMD_WRITE) && entry.wr_en;
    assign wr_addr = AW'(entry.pos_y) * AW'(MAX_WIDTH) + AW'(entry.pos_x);
    assign rd_fire = (state_reg == ST_SCAN);
    assign rd_addr = AW'(y_reg) * AW'(MAX_WIDTH) + AW'(x_reg);

    always_comb begin
        dx       = $signed({1'b0, x_reg}) - $signed((CW + 1)'(cx_reg));
        dy       = $signed({1'b0, y_reg}) - $signed((CW + 1)'(cy_reg));
        dxe      = QW'(dx);
        dye      = QW'(dy);
        sq_next  = $unsigned(dxe * dxe) + $unsigned(dye * dye);
        x_inc    = x_reg + CW'(1);
        y_inc    = y_reg + CW'(1);
        row_end  = (x_inc == xe_reg);
        last_pix = row_end && (y_inc == ye_reg);
        hit      = rd_bit_reg && ((CMPW'(sq_reg) << (2 * RADIUS_FRAC_BITS)) < CMPW'(r2_reg));
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mask_mem[wr_addr] <= entry.wr_bit;
        end
        if (rd_fire) begin
            rd_bit_reg <= mask_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pv_reg      <= 1'b0;
            acc_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pv_reg <= rd_fire;
            sq_reg <= sq_next;
            if (pv_reg) begin
                acc_reg <= acc_reg | hit;
            end
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop && (entry.cmd == mdpq_pkg::CMD_QUERY)) begin
                        x_reg   <= entry.xs;
                        y_reg   <= entry.ys;
                        xs_reg  <= entry.xs;
                        xe_reg  <= entry.xe;
                        ye_reg  <= entry.ye;
                        cx_reg  <= entry.pos_x;
                        cy_reg  <= entry.pos_y;
                        r2_reg  <= R2W'(entry.radius) * R2W'(entry.radius);
                        acc_reg <= 1'b0;
                        state_reg <= entry.empty ? ST_FIN : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (last_pix) begin
                        state_reg <= ST_DRAIN;
                    end else if (row_end) begin
                        x_reg <= xs_reg;
                        y_reg <= y_inc;
                    end else begin
                        x_reg <= x_inc;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_in_proximity_reg <= acc_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_in_proximity = m_in_proximity_reg;

endmodule

// File: sv/mask_disc_proximity_query_core.sv
// ----------------------------------------------------------------------------
// mask_disc_proximity_query_core
// binary mask store answering whether a set pixel lies inside an open disc
// ----------------------------------------------------------------------------
// a write request is done by the back end when popped; a query is popped, then
// scans its window one pixel per cycle, then drains and loads the result; an
// empty window skips the scan and drain, and the largest clipped window is
// 64 by 64 pixels; the result load waits while an earlier result is unaccepted
// reset clears control state and sets both grid sizes to 64; the mask memory
// is not cleared, every pixel must be written before a query reads it
module mask_disc_proximity_query_core #(
    parameter int MAX_WIDTH        = mdpq_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT       = mdpq_pkg::MAX_HEIGHT_DEF,
    parameter int RADIUS_FRAC_BITS = mdpq_pkg::RADIUS_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic [mdpq_pkg::POS_W-1:0]         s_pos_x,
    input  logic [mdpq_pkg::POS_W-1:0]         s_pos_y,
    input  logic [mdpq_pkg::PIX_W-1:0]         s_pixel_value,
    input  logic [mdpq_pkg::RADIUS_W-1:0]      s_radius_q4,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_in_proximity,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mdpq_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mdpq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mdpq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int GW = mdpq_pkg::GRID_W;
    localparam int DW = mdpq_pkg::APB_DATA_W;

    logic [GW-1:0]       grid_width_reg;
    logic [GW-1:0]       grid_height_reg;
    mdpq_pkg::reg_idx_t  reg_idx;
    logic                cfg_wr;
    mdpq_pkg::entry_t    front_entry;
    mdpq_pkg::entry_t    queue_entry;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;

    assign pready  = 1'b1;
    assign reg_idx = mdpq_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GW'(64);
            grid_height_reg <= GW'(64);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                mdpq_pkg::REG_GRID_WIDTH:  grid_width_reg  <= pwdata[GW-1:0];
                mdpq_pkg::REG_GRID_HEIGHT: grid_height_reg <= pwdata[GW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mdpq_pkg::REG_GRID_WIDTH:  prdata = DW'(grid_width_reg);
            mdpq_pkg::REG_GRID_HEIGHT: prdata = DW'(grid_height_reg);
            default:                   prdata = '0;
        endcase
    end

    assign s_ready = !q_full;

    mdpq_front #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_HEIGHT       (MAX_HEIGHT),
        .RADIUS_FRAC_BITS (RADIUS_FRAC_BITS)
    ) u_front (
        .s_command     (s_command),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pixel_value (s_pixel_value),
        .s_radius_q4   (s_radius_q4),
        .grid_width    (grid_width_reg),
        .grid_height   (grid_height_reg),
        .entry         (front_entry)
    );

    mdpq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (queue_entry),
        .empty     (q_empty)
    );

    mdpq_back #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_HEIGHT       (MAX_HEIGHT),
        .RADIUS_FRAC_BITS (RADIUS_FRAC_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .entry          (queue_entry),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_in_proximity (m_in_proximity)
    );

endmodule

// File: test/proximity_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_checker
// watches the request, result and register ports of the mask disc proximity
// query core, keeps its own mask and grid size, works out the answer of each
// accepted query and compares it with the result that comes back in order
// ----------------------------------------------------------------------------
module proximity_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_command,
    input  logic [mdpq_pkg::POS_W-1:0]      s_pos_x,
    input  logic [mdpq_pkg::POS_W-1:0]      s_pos_y,
    input  logic [mdpq_pkg::PIX_W-1:0]      s_pixel_value,
    input  logic [mdpq_pkg::RADIUS_W-1:0]   s_radius_q4,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_in_proximity,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [mdpq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mdpq_pkg::APB_DATA_W-1:0] pwdata,
    output int                              fail_count,
    output int                              pending_results
);

    localparam int GW    = mdpq_pkg::GRID_W;
    localparam int MW    = mdpq_pkg::MAX_WIDTH_DEF;
    localparam int MH    = mdpq_pkg::MAX_HEIGHT_DEF;
    localparam int FRAC  = mdpq_pkg::RADIUS_FRAC_BITS_DEF;

    logic [GW-1:0] grid_width_q  = 7'd64;
    logic [GW-1:0] grid_height_q = 7'd64;
    bit            mask_bits [0:MH-1][0:MW-1];
    logic          proximity_q [$];

    function automatic int used_size(logic [GW-1:0] v, int lim);
        return (v > lim) ? lim : int'(v);
    endfunction

    // open disc test over the clipped square window around the centre
    function automatic logic disc_hit(int cx, int cy, int rq);
        int     w;
        int     h;
        int     half;
        int     xs;
        int     xe;
        int     ys;
        int     ye;
        longint dx;
        longint dy;
        longint r2;
        longint d2;
        w    = used_size(grid_width_q, MW);
        h    = used_size(grid_height_q, MH);
        half = (rq + (1 << FRAC) - 1) >> FRAC;
        r2   = longint'(rq) * longint'(rq);
        xs   = (cx - half < 0) ? 0 : cx - half;
        ys   = (cy - half < 0) ? 0 : cy - half;
        xe   = (cx + half > w) ? w : cx + half;
        ye   = (cy + half > h) ? h : cy + half;
        for (int y = ys; y < ye; y++) begin
            for (int x = xs; x < xe; x++) begin
                if (mask_bits[y][x]) begin
                    dx = x - cx;
                    dy = y - cy;
                    d2 = dx * dx + dy * dy;
                    if ((d2 << (2 * FRAC)) < r2) begin
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        logic exp_bit;
        if (!aresetn) begin
            grid_width_q  = 7'd64;
            grid_height_q = 7'd64;
            proximity_q.delete();
            fail_count = 0;
            pending_results <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {mdpq_pkg::REG_GRID_WIDTH, 2'b00}) begin
                    grid_width_q = pwdata[GW-1:0];
                end else if (paddr == {mdpq_pkg::REG_GRID_HEIGHT, 2'b00}) begin
                    grid_height_q = pwdata[GW-1:0];
                end
            end
            if (s_valid && s_ready) begin
                if (s_command == mdpq_pkg::CMD_WRITE) begin
                    if (int'(s_pos_x) < used_size(grid_width_q, MW) &&
                        int'(s_pos_y) < used_size(grid_height_q, MH)) begin
                        mask_bits[s_pos_y][s_pos_x] = (s_pixel_value != '0);
                    end
                end else begin
                    proximity_q.push_back(disc_hit(int'(s_pos_x), int'(s_pos_y),
                                                   int'(s_radius_q4)));
                end
            end
            if (m_valid && m_ready) begin
                if (proximity_q.size() == 0) begin
                    $error("in_proximity: result %0b with no query pending", m_in_proximity);
                    fail_count++;
                end else begin
                    exp_bit = proximity_q.pop_front();
                    if (m_in_proximity !== exp_bit) begin
                        $error("in_proximity mismatch: expected %0b, actual %0b",
                               exp_bit, m_in_proximity);
                        fail_count++;
                    end
                end
            end
            pending_results <= proximity_q.size();
        end
    end

endmodule

// File: test/mask_disc_proximity_query_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_disc_proximity_query_core_tb
// drives mask writes and disc queries into the core across several grid
// sizes, with random idling on both sides and a long result stall; the
// checker predicts every answer and the verdict comes from its failure and pending result count
// ----------------------------------------------------------------------------
module mask_disc_proximity_query_core_tb;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int PHASE_ITEMS  = 60;
    localparam int NUM_PHASES   = 9;
    localparam int PW           = mdpq_pkg::POS_W;
    localparam int XW           = mdpq_pkg::PIX_W;
    localparam int RW           = mdpq_pkg::RADIUS_W;
    localparam int MW           = mdpq_pkg::MAX_WIDTH_DEF;
    localparam int MH           = mdpq_pkg::MAX_HEIGHT_DEF;

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic                            s_command     = 1'b0;
    logic [PW-1:0]                   s_pos_x       = '0;
    logic [PW-1:0]                   s_pos_y       = '0;
    logic [XW-1:0]                   s_pixel_value = '0;
    logic [RW-1:0]                   s_radius_q4   = '0;
    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic                            m_in_proximity;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [mdpq_pkg::APB_ADDR_W-1:0] paddr         = '0;
    logic [mdpq_pkg::APB_DATA_W-1:0] pwdata        = '0;
    logic [mdpq_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int fail_count;
    int pending_results;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_trig     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cycle_cnt     = 0;
    int used_w        = 64;
    int used_h        = 64;
    int phase_w [NUM_PHASES] = '{8, 1, 64, 17, 0, 127, 4, 9, 2};
    int phase_h [NUM_PHASES] = '{8, 64, 1, 5, 40, 3, 127, 12, 2};
    bit written [0:MH-1][0:MW-1];

    mask_disc_proximity_query_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pixel_value  (s_pixel_value),
        .s_radius_q4    (s_radius_q4),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_in_proximity (m_in_proximity),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    proximity_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_pixel_value   (s_pixel_value),
        .s_radius_q4     (s_radius_q4),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_in_proximity  (m_in_proximity),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic int pix_draw(int density);
        return ($urandom_range(99) < density) ? $urandom_range(1, 255) : 0;
    endfunction

    task automatic send_req(mdpq_pkg::cmd_t cmd, int x, int y, int pix, int rq);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_pos_x       <= x[PW-1:0];
        s_pos_y       <= y[PW-1:0];
        s_pixel_value <= pix[XW-1:0];
        s_radius_q4   <= rq[RW-1:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_query();
        int x;
        int y;
        int r;
        int sel;
        x = ($urandom_range(99) < 85) ? $urandom_range(0, (used_w + 1 > 63) ? 63 : used_w + 1)
                                      : $urandom_range(63);
        y = ($urandom_range(99) < 85) ? $urandom_range(0, (used_h + 1 > 63) ? 63 : used_h + 1)
                                      : $urandom_range(63);
        sel = $urandom_range(99);
        r = (sel < 70) ? $urandom_range(48) : (sel < 90) ? $urandom_range(160)
                                                         : $urandom_range(1023);
        send_req(mdpq_pkg::CMD_QUERY, x, y, $urandom_range(255), r);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(mdpq_pkg::reg_idx_t idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FF80) | (value & 32'h7F);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_grid(int w, int h);
        wait_drained();
        write_reg(mdpq_pkg::REG_GRID_WIDTH, w);
        write_reg(mdpq_pkg::REG_GRID_HEIGHT, h);
        used_w = (w > MW) ? MW : w;
        used_h = (h > MH) ? MH : h;
    endtask

    // every pixel of the grid in use gets written before any query can read it
    task automatic fill_grid(int density);
        for (int y = 0; y < used_h; y++) begin
            for (int x = 0; x < used_w; x++) begin
                if (!written[y][x]) begin
                    send_req(mdpq_pkg::CMD_WRITE, x, y, pix_draw(density),
                             $urandom_range(1023));
                    written[y][x] = 1'b1;
                end
            end
        end
    endtask

    initial begin
        int density;
        int x;
        int y;
        repeat (3) @(posedge aclk);
        aresetn       <= 1'b1;
        send_idle_pct = 29;
        recv_idle_pct <= 82;

        // zero radius reads nothing, so it is legal before any write
        send_req(mdpq_pkg::CMD_QUERY, 0, 0, 0, 0);
        send_req(mdpq_pkg::CMD_QUERY, 63, 63, 255, 0);

        // empty grid
        set_grid(0, 37);
        send_req(mdpq_pkg::CMD_WRITE, 10, 10, 255, 1023);
        send_req(mdpq_pkg::CMD_QUERY, 63, 63, 0, 1023);
        send_req(mdpq_pkg::CMD_QUERY, 0, 0, 0, 1023);

        // single pixel grid: disc boundary, clipping and writes outside the grid
        set_grid(1, 1);
        send_req(mdpq_pkg::CMD_WRITE, 0, 0, 255, 0);
        written[0][0] = 1'b1;
        send_req(mdpq_pkg::CMD_WRITE, 1, 0, 255, 0);
        send_req(mdpq_pkg::CMD_WRITE, 0, 1, 255, 0);
        send_req(mdpq_pkg::CMD_QUERY, 0, 0, 0, 16);
        send_req(mdpq_pkg::CMD_QUERY, 1, 0, 0, 16);
        send_req(mdpq_pkg::CMD_QUERY, 1, 0, 0, 17);
        send_req(mdpq_pkg::CMD_QUERY, 0, 63, 0, 1023);
        send_req(mdpq_pkg::CMD_QUERY, 63, 63, 0, 1023);
        send_req(mdpq_pkg::CMD_QUERY, 0, 0, 0, 0);
        send_req(mdpq_pkg::CMD_WRITE, 0, 0, 0, 0);
        send_req(mdpq_pkg::CMD_QUERY, 0, 0, 0, 1023);
        send_req(mdpq_pkg::CMD_WRITE, 0, 0, 1, 0);
        send_req(mdpq_pkg::CMD_QUERY, 1, 1, 0, 23);
        send_req(mdpq_pkg::CMD_WRITE, 0, 0, 128, 0);
        send_req(mdpq_pkg::CMD_QUERY, 63, 0, 0, 1023);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 82;
                recv_idle_pct <= 29;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            set_grid(phase_w[ph], phase_h[ph]);
            density = $urandom_range(5, 60);
            fill_grid(density);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 0 && k == PHASE_ITEMS / 2) begin
                    // long result stall fills the core, then let it empty out
                    hold_trig <= hold_trig + 1;
                    repeat (12) send_random_query();
                    wait_drained();
                end
                if ($urandom_range(1) == 0) begin
                    if (used_w > 0 && used_h > 0 && $urandom_range(99) < 85) begin
                        x = $urandom_range(0, used_w - 1);
                        y = $urandom_range(0, used_h - 1);
                    end else begin
                        x = $urandom_range(63);
                        y = $urandom_range(63);
                    end
                    send_req(mdpq_pkg::CMD_WRITE, x, y, pix_draw(density),
                             $urandom_range(1023));
                end else begin
                    send_random_query();
                end
            end
        end

        wait_drained();
        if (fail_count == 0 && pending_results == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
